### src/erot_pkg.sv
// shared types and constants of the rotor stage
`default_nettype none

package erot_pkg;

    // alphabet and field widths
    localparam int ALPHA_SIZE = 26;
    localparam int LETTER_W   = 5;
    localparam int REV_W      = 16;
    localparam int IDX_W      = $clog2(ALPHA_SIZE);
    localparam int CNT_W      = $clog2(ALPHA_SIZE + 1);
    localparam int ACTION_W   = 2;

    localparam logic [LETTER_W-1:0] ALPHA_L    = LETTER_W'(ALPHA_SIZE);
    localparam logic [CNT_W-1:0]    ALPHA_CNT  = CNT_W'(ALPHA_SIZE);
    localparam logic [LETTER_W-1:0] ALPHA_LAST = LETTER_W'(ALPHA_SIZE - 1);

    // input transaction: letter_in then wiring_value, padded to bytes
    localparam int IN_FIELDS_W = 2 * LETTER_W;
    localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;

    // item kinds carried on tuser
    typedef enum logic [ACTION_W-1:0] {
        ACT_LOAD    = 2'd0,
        ACT_ROTATE  = 2'd1,
        ACT_FORWARD = 2'd2,
        ACT_INVERSE = 2'd3
    } action_t;

    // result fields, first field in the highest bits
    typedef struct packed {
        logic                load_error;
        logic                wrapped;
        logic [REV_W-1:0]    revolutions;
        logic [LETTER_W-1:0] offset_now;
        logic                matched;
        logic [LETTER_W-1:0] letter_out;
    } result_t;

    localparam int RES_W      = $bits(result_t);
    localparam int OUT_DATA_W = ((RES_W + 7) / 8) * 8;

    // controller state
    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic commit;
    } ctrl_cmd_t;

endpackage

`default_nettype wire

### src/erot_ctrl.sv
// controller state machine of the rotor stage
`default_nettype none

module erot_ctrl
    import erot_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    output ctrl_cmd_t      cmd
);

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   commit;

    // output register can take a new result when empty or draining
    assign commit = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (commit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
            end
            ST_EXEC:
            begin
                cmd.commit = commit;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // output valid flag
    always_comb
    begin
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // an accepted transaction is worked on in the next cycle
    a_capture_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == ST_EXEC))
        else $error("accepted transaction did not enter execution");

    // a stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EXEC && out_valid_reg && !out_ready)
            |=> (state_reg == ST_EXEC && out_valid_reg))
        else $error("pending result overwritten while stalled");

    // a committed result is presented in the next cycle
    a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (out_valid_reg && state_reg == ST_IDLE))
        else $error("committed result not presented");

endmodule

`default_nettype wire

### src/erot_dpath.sv
// datapath of the rotor stage: wiring table, offset, revolution count, result register
`default_nettype none

module erot_dpath
    import erot_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ctrl_cmd_t             cmd,
    input  wire logic [IN_DATA_W-1:0]  in_data,
    input  wire logic [ACTION_W-1:0]   in_kind,
    output logic [OUT_DATA_W-1:0]      out_data
);

    // wiring table, undefined until loaded
    logic [LETTER_W-1:0]   wiring_reg [ALPHA_SIZE];

    // captured transaction
    action_t               action_reg;
    logic [LETTER_W-1:0]   letter_reg;
    logic [LETTER_W-1:0]   wval_reg;
    logic [ALPHA_SIZE-1:0] hit_reg;
    logic [ALPHA_SIZE-1:0] hit_next;
    logic [LETTER_W-1:0]   letter_in;

    // rotor state
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic [LETTER_W-1:0]   offset_reg;
    logic [LETTER_W-1:0]   offset_next;
    logic [REV_W-1:0]      rev_reg;
    logic [REV_W-1:0]      rev_next;

    result_t               res_reg;
    result_t               res_next;

    // execution terms
    logic [LETTER_W-1:0]   letter_red;
    logic [LETTER_W-1:0]   wval_red;
    logic [LETTER_W:0]     fwd_sum;
    logic [LETTER_W-1:0]   fwd_pos;
    logic [IDX_W-1:0]      hit_idx;
    logic                  hit_any;
    logic [LETTER_W-1:0]   inv_pos;
    logic [LETTER_W-1:0]   inv_out;
    logic                  table_full;
    logic                  table_we;

    assign letter_in = in_data[LETTER_W-1:0];

    // compare every loaded entry against the incoming letter
    always_comb
    begin
        for (int i = 0; i < ALPHA_SIZE; i++)
        begin
            hit_next[i] = (count_reg > CNT_W'(i)) && (wiring_reg[i] == letter_in);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            action_reg <= action_t'(in_kind);
            letter_reg <= letter_in;
            wval_reg   <= in_data[2*LETTER_W-1:LETTER_W];
            hit_reg    <= hit_next;
        end
    end

    // reduce inputs into the alphabet
    assign letter_red = (letter_reg >= ALPHA_L) ? (letter_reg - ALPHA_L) : letter_reg;
    assign wval_red   = (wval_reg >= ALPHA_L) ? (wval_reg - ALPHA_L) : wval_reg;

    // forward position
    assign fwd_sum = {1'b0, letter_red} + {1'b0, offset_reg};
    assign fwd_pos = (fwd_sum >= {1'b0, ALPHA_L}) ? LETTER_W'(fwd_sum - {1'b0, ALPHA_L})
                                                  : fwd_sum[LETTER_W-1:0];

    // lowest matching entry
    always_comb
    begin
        hit_idx = '0;
        for (int i = ALPHA_SIZE - 1; i >= 0; i--)
        begin
            if (hit_reg[i])
            begin
                hit_idx = IDX_W'(i);
            end
        end
    end

    assign hit_any = |hit_reg;
    assign inv_pos = hit_any ? LETTER_W'(hit_idx) : letter_red;
    assign inv_out = (inv_pos >= offset_reg) ? (inv_pos - offset_reg)
                                             : (inv_pos + ALPHA_L - offset_reg);

    assign table_full = (count_reg == ALPHA_CNT);

    // result and next rotor state
    always_comb
    begin
        count_next  = count_reg;
        offset_next = offset_reg;
        rev_next    = rev_reg;
        table_we    = 1'b0;
        res_next    = '0;
        unique case (action_reg)
            ACT_LOAD:
            begin
                offset_next = '0;
                if (table_full)
                begin
                    res_next.load_error = 1'b1;
                end
                else
                begin
                    table_we   = 1'b1;
                    count_next = count_reg + CNT_W'(1);
                end
            end
            ACT_ROTATE:
            begin
                if (offset_reg == ALPHA_LAST)
                begin
                    offset_next      = '0;
                    rev_next         = rev_reg + REV_W'(1);
                    res_next.wrapped = 1'b1;
                end
                else
                begin
                    offset_next = offset_reg + LETTER_W'(1);
                end
            end
            ACT_FORWARD:
            begin
                if (CNT_W'(fwd_pos) < count_reg)
                begin
                    res_next.letter_out = wiring_reg[fwd_pos[IDX_W-1:0]];
                    res_next.matched    = 1'b1;
                end
                else
                begin
                    res_next.letter_out = fwd_pos;
                end
            end
            ACT_INVERSE:
            begin
                res_next.letter_out = inv_out;
                res_next.matched    = hit_any;
            end
            default:
            begin
                res_next = '0;
            end
        endcase
        res_next.offset_now  = offset_next;
        res_next.revolutions = rev_next;
    end

    // wiring table write
    always_ff @(posedge clk)
    begin
        if (cmd.commit && table_we)
        begin
            wiring_reg[count_reg[IDX_W-1:0]] <= wval_red;
        end
    end

    // rotor state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            offset_reg <= '0;
            rev_reg    <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg  <= count_next;
            offset_reg <= offset_next;
            rev_reg    <= rev_next;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_reg <= res_next;
        end
    end

    assign out_data = {{(OUT_DATA_W - RES_W){1'b0}}, res_reg};

    // fill count never passes the table size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= ALPHA_CNT)
        else $error("wiring fill count out of range");

    // offset stays inside the alphabet
    a_offset_range: assert property (@(posedge clk) disable iff (!rst_n)
        offset_reg < ALPHA_L)
        else $error("rotation offset out of range");

    // rotor state only moves on a committed transaction
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd.commit |=> ($stable(count_reg) && $stable(offset_reg) && $stable(rev_reg)))
        else $error("rotor state changed without a commit");

endmodule

`default_nettype wire

### src/enigma_rotor_stage.sv
// top level of the rotor stage: controller plus datapath behind stream ports
//
// Usage
//   Input stream: one transaction per item. tuser carries the item kind
//   (load wiring entry, rotate, forward encode, inverse encode); tdata
//   carries letter_in and wiring_value.
//   Output stream: one transaction per item, carrying the encoded letter,
//   the match flag, the offset and revolution count after the item, the
//   wrap flag and the load error flag.
//   Sequence: the controller captures the item and compares it against the
//   loaded wiring entries in the accepting cycle, then in the execute state
//   resolves the lowest match and commits the result and the state update
//   once the output register is empty or draining. A new item is not
//   accepted until the current one has been committed.
//   Reset clears the fill count, offset, revolution count and output valid;
//   the wiring table holds nothing usable until entries are loaded.
//   A stalled receiver holds the result in the output register; the next
//   item is still accepted and worked on, and waits for the register to
//   drain before it updates the rotor state.
`default_nettype none

module enigma_rotor_stage
    import erot_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,   // letter_in, wiring_value
    input  wire logic [ACTION_W-1:0]   s_axis_tuser,   // action
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata    // letter_out, matched, offset_now,
                                                       // revolutions, wrapped, load_error
);

    ctrl_cmd_t cmd;

    erot_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd)
    );

    erot_dpath u_dpath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .in_data  (s_axis_tdata),
        .in_kind  (s_axis_tuser),
        .out_data (m_axis_tdata)
    );

endmodule

`default_nettype wire
